[rtl/mah_pkg.sv]
package mah_pkg;

	// result given to a low address that no active range holds
	localparam logic [63:0] NO_MATCH_LOW  = 64'h0000_0000_0000_1337;
	localparam logic [63:0] NO_MATCH_HIGH = 64'h0000_0000_0000_1338;

	// one table entry, end already resolved as base plus length
	typedef struct packed {
		logic [63:0] range_base;
		logic [63:0] range_end;
		logic [63:0] ident_low;
		logic [63:0] ident_high;
	} entry_t;

	// lookup sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

[rtl/mah_table.sv]
module mah_table import mah_pkg::*; #(
	parameter int TABLE_DEPTH = 64,
	parameter int IDX_W       = 6
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem_q [TABLE_DEPTH];

	// single write port, loads only
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port, one entry a cycle
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/module_address_hash.sv]
// Address range resolver. A load item (kind = 1) writes one table entry in the
// cycle it is accepted and gives no result; busy stays low. A lookup item
// (kind = 0) scans the table from entry zero, one entry a cycle through the
// single read port of the table memory, and stops at the first range holding
// the address. busy goes high once the lookup is accepted and falls in the cycle
// the result is shown. The result appears for exactly one cycle with done high
// and cannot be held off, so the receiver must take it in that cycle. The user
// must write active_entries through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. Entries must be loaded before a
// lookup searches them; the table has no reset.
module module_address_hash import mah_pkg::*; #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        kind,
	input  logic [63:0] address,
	input  logic [5:0]  entry_index,
	input  logic [63:0] entry_base,
	input  logic [63:0] entry_length,
	input  logic [63:0] entry_hash_low,
	input  logic [63:0] entry_hash_high,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	output logic        done,
	output logic [63:0] hash_low,
	output logic [63:0] hash_high,
	output logic        found,
	output logic [5:0]  match_index
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	state_t             state_q, state_d;
	logic [6:0]         active_q;
	logic [CNT_W-1:0]   limit_d, limit_q;
	logic [CNT_W-1:0]   rd_q;
	logic               valid_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic [63:0]        addr_q;
	logic               hit_q;
	logic [5:0]         hit_idx_q;
	logic [63:0]        diff_q, lo_q, hi_q;
	logic               done_q, found_q;
	logic [63:0]        hash_low_q, hash_high_q;
	logic [5:0]         match_index_q;

	logic               accept, do_load, do_lookup;
	logic               issue, hit;
	logic               load_in_range;
	logic [64:0]        diff;
	entry_t             wr_entry, rd_entry;

	assign accept    = start && (state_q == ST_IDLE);
	assign do_load   = accept && kind;
	assign do_lookup = accept && !kind;
	assign busy      = (state_q != ST_IDLE);

	// slots beyond the table are dropped
	assign load_in_range = 32'(entry_index) < 32'(TABLE_DEPTH);

	// entry to write, end resolved here once
	always_comb begin
		wr_entry.range_base = entry_base;
		wr_entry.range_end  = entry_base + entry_length;
		wr_entry.ident_low  = entry_hash_low;
		wr_entry.ident_high = entry_hash_high;
	end

	mah_table #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.IDX_W       (IDX_W)
	) u_table (
		.clk   (clk),
		.we    (do_load && load_in_range),
		.waddr (IDX_W'(entry_index)),
		.wdata (wr_entry),
		.raddr (rd_q[IDX_W-1:0]),
		.rdata (rd_entry)
	);

	// number of entries searched, clipped to the table
	always_comb begin
		if (32'(active_q) > 32'(TABLE_DEPTH)) begin
			limit_d = CNT_W'(TABLE_DEPTH);
		end else begin
			limit_d = CNT_W'(active_q);
		end
	end

	// range test: no borrow on address - base, and address below end
	assign diff  = {1'b0, addr_q} - {1'b0, rd_entry.range_base};
	assign hit   = valid_s1 && !diff[64] && (addr_q < rd_entry.range_end);
	assign issue = (state_q == ST_SCAN) && !hit && (rd_q < limit_q);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (do_lookup) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || (!valid_s1 && (rd_q == limit_q))) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers: config, search limit, read pointer, read pipeline flag, hit flag, strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			limit_q  <= '0;
			rd_q     <= '0;
			valid_s1 <= 1'b0;
			hit_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				active_q <= cfg_wdata;
			end
			valid_s1 <= issue;
			done_q   <= (state_q == ST_FINISH);
			if (do_lookup) begin
				limit_q <= limit_d;
				rd_q    <= '0;
				hit_q   <= 1'b0;
			end else begin
				if (issue) begin
					rd_q <= rd_q + 1'b1;
				end
				if (hit) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (do_lookup) begin
			addr_q <= address;
		end
		if (issue) begin
			idx_s1 <= rd_q[IDX_W-1:0];
		end
		// hold the winning entry
		if (hit) begin
			diff_q    <= diff[63:0];
			lo_q      <= rd_entry.ident_low;
			hi_q      <= rd_entry.ident_high;
			hit_idx_q <= 6'(idx_s1);
		end
		// build the result item
		if (state_q == ST_FINISH) begin
			found_q <= hit_q;
			if (hit_q) begin
				hash_low_q    <= lo_q + diff_q;
				hash_high_q   <= hi_q;
				match_index_q <= hit_idx_q;
			end else if (addr_q[63]) begin
				hash_low_q    <= addr_q;
				hash_high_q   <= '0;
				match_index_q <= '0;
			end else begin
				hash_low_q    <= NO_MATCH_LOW;
				hash_high_q   <= NO_MATCH_HIGH;
				match_index_q <= '0;
			end
		end
	end

	assign done        = done_q;
	assign found       = found_q;
	assign hash_low    = hash_low_q;
	assign hash_high   = hash_high_q;
	assign match_index = match_index_q;

	// a result only ever follows the finish step
	a_done_after_finish: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result strobe without a finished lookup");

	// a lookup holds the block busy, a load does not
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !kind) |=> busy)
		else $error("lookup accepted but block not busy");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && kind) |=> !busy)
		else $error("load item left the block busy");

	// read pointer never runs past the searched span
	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_q <= limit_q))
		else $error("scan pointer beyond active entries");

endmodule

[bench/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TBL_DEPTH = 64;
	localparam int SETTLE = TBL_DEPTH + 8;
	localparam bit KIND_LOOKUP = 1'b0;
	localparam bit KIND_LOAD = 1'b1;
	localparam logic [63:0] MISS_LOW = 64'h0000_0000_0000_1337;
	localparam logic [63:0] MISS_HIGH = 64'h0000_0000_0000_1338;
	localparam logic [63:0] TOP_BIT = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] CLUSTER = 64'h0000_4000_0000_0000;

	// one item as handed to the block
	typedef struct {
		bit        kind;
		bit [63:0] address;
		bit [5:0]  index;
		bit [63:0] base;
		bit [63:0] length;
		bit [63:0] h_lo;
		bit [63:0] h_hi;
	} req_t;

	// resolved address hash of one lookup
	typedef struct {
		logic [63:0] lo;
		logic [63:0] hi;
		logic        hit;
		logic [5:0]  idx;
	} hash_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        kind = KIND_LOOKUP;
	logic [63:0] address = '0;
	logic [5:0]  entry_index = '0;
	logic [63:0] entry_base = '0;
	logic [63:0] entry_length = '0;
	logic [63:0] entry_hash_low = '0;
	logic [63:0] entry_hash_high = '0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        busy;
	logic        done;
	logic [63:0] hash_low;
	logic [63:0] hash_high;
	logic        found;
	logic [5:0]  match_index;

	// table as the block should hold it, updated in order of acceptance
	logic [63:0] tbl_base [TBL_DEPTH];
	logic [63:0] tbl_end [TBL_DEPTH];
	logic [63:0] tbl_lo [TBL_DEPTH];
	logic [63:0] tbl_hi [TBL_DEPTH];
	int          search_count = 0;

	// table contents as seen at the tail of the item queue, for aiming lookups
	bit [63:0]   gen_base [TBL_DEPTH] = '{default: '0};
	bit [63:0]   gen_len [TBL_DEPTH] = '{default: '0};

	req_t        req_queue [$];
	hash_res_t   expected_hashes [$];
	req_t        cur_req;
	hash_res_t   predicted;
	hash_res_t   want;

	int          gap = 0;
	int          no_idle_left = 0;
	bit          draining = 1'b0;
	int          n_accepted = 0;
	int          n_lookups = 0;
	int          n_results = 0;
	int          n_loads = 0;
	int          n_hits = 0;
	int          n_miss_top = 0;
	int          n_miss_low = 0;
	int          n_cfg = 0;
	int          n_errors = 0;

	module_address_hash #(.TABLE_DEPTH(TBL_DEPTH)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.kind(kind),
		.address(address),
		.entry_index(entry_index),
		.entry_base(entry_base),
		.entry_length(entry_length),
		.entry_hash_low(entry_hash_low),
		.entry_hash_high(entry_hash_high),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.done(done),
		.hash_low(hash_low),
		.hash_high(hash_high),
		.found(found),
		.match_index(match_index)
	);

	always #5 clk = ~clk;

	function automatic bit [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	// first active range holding the address wins, else one of the two miss forms
	function automatic hash_res_t resolve_address(logic [63:0] addr);
		hash_res_t r;
		int lim;
		lim = (search_count > TBL_DEPTH) ? TBL_DEPTH : search_count;
		r.lo = addr[63] ? addr : MISS_LOW;
		r.hi = addr[63] ? 64'h0 : MISS_HIGH;
		r.hit = 1'b0;
		r.idx = '0;
		for (int i = 0; i < lim; i++) begin
			if (addr >= tbl_base[i] && addr < tbl_end[i]) begin
				r.lo = tbl_lo[i] + (addr - tbl_base[i]);
				r.hi = tbl_hi[i];
				r.hit = 1'b1;
				r.idx = 6'(i);
				return r;
			end
		end
		return r;
	endfunction

	function automatic void push_load(bit [5:0] idx, bit [63:0] base, bit [63:0] len,
			bit [63:0] lo, bit [63:0] hi);
		req_t r;
		r.kind = KIND_LOAD;
		r.address = rand64();
		r.index = idx;
		r.base = base;
		r.length = len;
		r.h_lo = lo;
		r.h_hi = hi;
		req_queue.push_back(r);
		gen_base[idx] = base;
		gen_len[idx] = len;
	endfunction

	// entry fields of a lookup are ignored, so they carry noise
	function automatic void push_lookup(bit [63:0] addr);
		req_t r;
		r.kind = KIND_LOOKUP;
		r.address = addr;
		r.index = 6'($urandom);
		r.base = rand64();
		r.length = rand64();
		r.h_lo = rand64();
		r.h_hi = rand64();
		req_queue.push_back(r);
	endfunction

	// small overlapping ranges in one region most often, plus empty, wrapped and huge ones
	function automatic void load_random(bit [5:0] idx);
		bit [63:0] base;
		bit [63:0] len;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				base = CLUSTER + $urandom_range(0, 4095);
				len = $urandom_range(1, 512);
			end
			4: begin
				base = rand64();
				len = {32'h0, $urandom};
			end
			5: begin
				base = TOP_BIT | rand64();
				len = $urandom_range(1, 1 << 20);
			end
			6: begin
				base = rand64();
				len = '0;
			end
			7: begin
				base = ALL_ONES - $urandom_range(0, 255);
				len = $urandom_range(256, 65535);
			end
			8: begin
				base = rand64();
				len = rand64();
			end
			default: begin
				base = {32'h0, $urandom};
				len = {32'h0, $urandom};
			end
		endcase
		push_load(idx, base, len, rand64(), rand64());
	endfunction

	// wait until nothing is queued or outstanding, then let the block settle
	task automatic wait_idle();
		do @(negedge clk); while (req_queue.size() != 0 || start || n_lookups != n_results);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic set_active(int v);
		wait_idle();
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		search_count = v;
		n_cfg++;
		@(negedge clk);
	endtask

	// one setting of the active count, then a mix of loads and aimed lookups
	task automatic run_phase(int act, int n);
		int lim;
		int sel;
		bit [5:0] e;
		bit [63:0] b;
		bit [63:0] l;
		set_active(act);
		lim = (act > TBL_DEPTH) ? TBL_DEPTH : act;
		repeat (n) begin
			if ($urandom_range(0, 99) < 15) begin
				load_random(6'($urandom));
			end else begin
				e = (lim > 0) ? 6'($urandom_range(0, lim - 1)) : 6'($urandom);
				b = gen_base[e];
				l = gen_len[e];
				sel = $urandom_range(0, 19);
				if (sel < 10) begin
					push_lookup((l != 0) ? b + rand64() % l : b);
				end else if (sel < 14) begin
					case ($urandom_range(0, 3))
						0: push_lookup(b);
						1: push_lookup(b + l - 1);
						2: push_lookup(b + l);
						default: push_lookup(b - 1);
					endcase
				end else if (sel < 16) begin
					push_lookup(CLUSTER + $urandom_range(0, 5000));
				end else if (sel < 18) begin
					push_lookup(rand64());
				end else begin
					case ($urandom_range(0, 3))
						0: push_lookup('0);
						1: push_lookup(ALL_ONES);
						2: push_lookup(TOP_BIT);
						default: push_lookup(~TOP_BIT);
					endcase
				end
			end
		end
	endtask

	// driver: present queued items, predict each one as it is taken
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			kind <= KIND_LOOKUP;
			address <= '0;
			entry_index <= '0;
			entry_base <= '0;
			entry_length <= '0;
			entry_hash_low <= '0;
			entry_hash_high <= '0;
		end else if (!(start && busy)) begin
			if (start) begin
				if (cur_req.kind == KIND_LOAD) begin
					tbl_base[cur_req.index] = cur_req.base;
					tbl_end[cur_req.index] = cur_req.base + cur_req.length;
					tbl_lo[cur_req.index] = cur_req.h_lo;
					tbl_hi[cur_req.index] = cur_req.h_hi;
					n_loads++;
				end else begin
					predicted = resolve_address(cur_req.address);
					expected_hashes.push_back(predicted);
					n_lookups++;
					if (predicted.hit)
						n_hits++;
					else if (cur_req.address[63])
						n_miss_top++;
					else
						n_miss_low++;
				end
				n_accepted++;
				// idle gap before the next item, with runs of back-to-back items
				if (no_idle_left > 0) begin
					no_idle_left--;
					gap = 0;
				end else if ($urandom_range(0, 29) == 0) begin
					no_idle_left = $urandom_range(20, 60);
					gap = 0;
				end else begin
					gap = $urandom_range(0, 19);
				end
				// now and then hold off until every lookup has answered
				if (n_accepted % 150 == 75 || $urandom_range(0, 59) == 0)
					draining = 1'b1;
			end
			if (draining && n_lookups == n_results)
				draining = 1'b0;
			if (gap > 0) begin
				gap--;
				start <= 1'b0;
			end else if (!draining && req_queue.size() != 0) begin
				cur_req = req_queue.pop_front();
				start <= 1'b1;
				kind <= cur_req.kind;
				address <= cur_req.address;
				entry_index <= cur_req.index;
				entry_base <= cur_req.base;
				entry_length <= cur_req.length;
				entry_hash_low <= cur_req.h_lo;
				entry_hash_high <= cur_req.h_hi;
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor: every strobed result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_hashes.size() == 0) begin
				$error("result with no lookup waiting: hash_low %h hash_high %h",
					hash_low, hash_high);
				n_errors++;
			end else begin
				want = expected_hashes.pop_front();
				n_results <= n_results + 1;
				if (hash_low !== want.lo) begin
					$error("hash_low: expected %h, actual %h", want.lo, hash_low);
					n_errors++;
				end
				if (hash_high !== want.hi) begin
					$error("hash_high: expected %h, actual %h", want.hi, hash_high);
					n_errors++;
				end
				if (found !== want.hit) begin
					$error("found: expected %b, actual %b", want.hit, found);
					n_errors++;
				end
				if (match_index !== want.idx) begin
					$error("match_index: expected %0d, actual %0d", want.idx, match_index);
					n_errors++;
				end
			end
		end
	end

	// stimulus
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// nothing active yet: both miss forms at the address extremes
		push_lookup('0);
		push_lookup(ALL_ONES);
		push_lookup(TOP_BIT);
		push_lookup(~TOP_BIT);

		// overlapping, empty, wrapped and full-span ranges, last slot at the extremes
		push_load(6'd0, 64'h1000, 64'h100, ALL_ONES, ALL_ONES);
		push_load(6'd1, 64'h5000, 64'h0, 64'h1, 64'h2);
		push_load(6'd2, ALL_ONES - 64'hFF, 64'h200, rand64(), rand64());
		push_load(6'd3, 64'h1080, 64'h1000, 64'h10, TOP_BIT);
		push_load(6'd4, '0, ALL_ONES, '0, '0);
		push_load(6'd5, TOP_BIT, 64'h10, rand64(), rand64());
		push_load(6'd63, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);

		// first match wins, hash wraps, empty and wrapped entries fall through
		set_active(6);
		push_lookup(64'h1000);
		push_lookup(64'h10FF);
		push_lookup(64'h1100);
		push_lookup(64'h5000);
		push_lookup(ALL_ONES - 64'h7F);
		push_lookup(ALL_ONES);
		push_lookup('0);

		set_active(1);
		push_lookup(64'h5000);
		push_lookup(64'h1050);

		// fill the whole table, then walk through the settings
		for (int i = 0; i < TBL_DEPTH; i++)
			load_random(6'(i));
		run_phase(TBL_DEPTH, 130);
		run_phase(127, 130);
		run_phase(TBL_DEPTH + 1, 130);
		run_phase(1, 130);
		run_phase(0, 100);
		run_phase(32, 130);
		run_phase($urandom_range(2, TBL_DEPTH - 1), 130);
		run_phase(100, 130);
		run_phase(TBL_DEPTH, 130);
		wait_idle();

		$display("tb: %0d loads, %0d lookups: %0d hits, %0d misses with bit 63 set, %0d low misses",
			n_loads, n_lookups, n_hits, n_miss_top, n_miss_low);
		$display("tb: %0d active count settings from 0 to 127", n_cfg);
		if (n_errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// watchdog
	initial begin
		#10ms;
		$display("tb: failure");
		$finish;
	end

endmodule
